@@ sv/pce_pkg.sv @@
// ----------------------------------------------------------------------------
// pce_pkg
// Shared codes and default sizes for the priority collection engine.
// ----------------------------------------------------------------------------
package pce_pkg;

   localparam int MAX_ENTRIES_DEF   = 64;
   localparam int DATA_BITS_DEF     = 32;
   localparam int PRIORITY_BITS_DEF = 16;
   localparam int ID_PORT_BITS      = 6;
   localparam int DATA_PORT_BITS    = 32;
   localparam int PRIO_PORT_BITS    = 16;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_PROMOTE = 3'd1,
      OP_PEEK    = 3'd2,
      OP_POP     = 3'd3,
      OP_READ    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_BADID = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

endpackage

@@ sv/priority_collection_engine.sv @@
// ----------------------------------------------------------------------------
// priority_collection_engine
// Max-priority table with add, promote, peek, pop and read.
// ----------------------------------------------------------------------------
// One command at a time: busy rises on start, and every command walks the
// scan word through the row of entry cells, one cell per cycle. rsp_strobe is
// high for one cycle once the word has passed the injection register, one
// register per cell and then the result register, and busy drops in that
// same cycle, so a new command can be accepted from the strobe cycle on.
// Results cannot be held off; capture them in the strobe cycle.
module priority_collection_engine #(
   parameter int MAX_ENTRIES   = pce_pkg::MAX_ENTRIES_DEF,
   parameter int DATA_BITS     = pce_pkg::DATA_BITS_DEF,
   parameter int PRIORITY_BITS = pce_pkg::PRIORITY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [5:0]  req_entry_id,
   input  logic [31:0] req_payload,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_result_id,
   output logic [31:0] rsp_result_data,
   output logic [15:0] rsp_result_priority,
   output logic        rsp_id_is_valid
);
   import pce_pkg::*;

   localparam int ID_BITS  = $clog2(MAX_ENTRIES);
   localparam int TGT_BITS = (ID_BITS + 1 > ID_PORT_BITS) ? ID_BITS + 1 : ID_PORT_BITS;
   localparam int WORD_BITS = 1 + 3 + TGT_BITS + DATA_BITS + 1 + ID_BITS + PRIORITY_BITS;

   typedef struct packed {
      logic                     live;
      logic [2:0]               op;
      logic [TGT_BITS-1:0]      tgt;
      logic [DATA_BITS-1:0]     data;
      logic                     hit;
      logic [ID_BITS-1:0]       bid;
      logic [PRIORITY_BITS-1:0] prio;
   } word_type;

   typedef struct packed {
      logic               en;
      logic [ID_BITS-1:0] id;
   } clr_type;

   logic [WORD_BITS-1:0] chain [0:MAX_ENTRIES];
   word_type             inj_ff, inj_in, last;
   clr_type              clr;
   logic [ID_BITS:0]     next_free_ff, next_free_in;
   logic                 busy_ff, busy_in;
   logic                 accept;
   logic                 strobe_ff;
   logic [1:0]           status_ff, status_in;
   logic [5:0]           id_ff, id_in;
   logic [31:0]          data_ff, data_in;
   logic [15:0]          prio_ff, prio_in;
   logic                 valid_ff, valid_in;

   assign accept = start && !busy_ff;
   assign chain[0] = inj_ff;
   assign last = chain[MAX_ENTRIES];

   genvar g;
   generate
      for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
         pce_cell #(
            .INDEX(g), .ID_BITS(ID_BITS), .TGT_BITS(TGT_BITS),
            .DATA_BITS(DATA_BITS), .PRIORITY_BITS(PRIORITY_BITS)
         ) u_cell (
            .clock(clock), .reset(reset),
            .word_i(chain[g]), .clr_i(clr), .word_o(chain[g+1])
         );
      end
   endgenerate

   always_comb begin
      inj_in       = '0;
      next_free_in = next_free_ff;
      if (accept) begin
         inj_in.live = 1'b1;
         inj_in.op   = req_operation;
         inj_in.data = DATA_BITS'(req_payload);
         if (req_operation == OP_ADD) begin
            inj_in.tgt = TGT_BITS'(next_free_ff);
            if (next_free_ff < (ID_BITS+1)'(MAX_ENTRIES)) next_free_in = next_free_ff + 1'b1;
         end else begin
            inj_in.tgt = TGT_BITS'(req_entry_id);
         end
      end
   end

   assign clr.en = last.live && last.op == OP_POP && last.hit;
   assign clr.id = last.bid;

   always_comb begin
      busy_in   = busy_ff;
      status_in = ST_OK;
      id_in     = '0;
      data_in   = '0;
      prio_in   = '0;
      valid_in  = 1'b0;
      if (accept) busy_in = 1'b1;
      if (last.live) begin
         busy_in = 1'b0;
         case (last.op)
            OP_ADD: begin
               if (last.hit) begin
                  id_in    = 6'(last.bid);
                  valid_in = 1'b1;
               end else begin
                  status_in = ST_FULL;
               end
            end
            OP_PROMOTE, OP_READ: begin
               if (last.hit) begin
                  id_in    = 6'(last.bid);
                  data_in  = 32'(last.data);
                  prio_in  = 16'(last.prio);
                  valid_in = 1'b1;
               end else begin
                  status_in = ST_BADID;
                  id_in     = 6'(last.tgt);
               end
            end
            OP_PEEK, OP_POP: begin
               if (last.hit) begin
                  id_in    = 6'(last.bid);
                  data_in  = 32'(last.data);
                  prio_in  = 16'(last.prio);
                  valid_in = 1'b1;
               end else begin
                  status_in = ST_EMPTY;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inj_ff       <= '0;
         next_free_ff <= '0;
         busy_ff      <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         inj_ff       <= inj_in;
         next_free_ff <= next_free_in;
         busy_ff      <= busy_in;
         strobe_ff    <= last.live;
      end
      status_ff <= status_in;
      id_ff     <= id_in;
      data_ff   <= data_in;
      prio_ff   <= prio_in;
      valid_ff  <= valid_in;
   end

   assign busy                = busy_ff;
   assign rsp_strobe          = strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_result_id       = id_ff;
   assign rsp_result_data     = data_ff;
   assign rsp_result_priority = prio_ff;
   assign rsp_id_is_valid     = valid_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff) else $error("busy not raised on start");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> !busy_ff) else $error("result while still busy");
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= (ID_BITS+1)'(MAX_ENTRIES)) else $error("free id past table");
   a_status_valid: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && valid_ff |-> status_ff == ST_OK) else $error("valid with error status");

endmodule

@@ sv/pce_cell.sv @@
// ----------------------------------------------------------------------------
// pce_cell
// One table entry. Updates its entry and the passing scan word, then hands
// the word to the next cell.
// ----------------------------------------------------------------------------
module pce_cell #(
   parameter int INDEX         = 0,
   parameter int ID_BITS       = 6,
   parameter int TGT_BITS      = 7,
   parameter int DATA_BITS     = 32,
   parameter int PRIORITY_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [1+3+TGT_BITS+DATA_BITS+1+ID_BITS+PRIORITY_BITS-1:0] word_i,
   input  logic [ID_BITS:0]                              clr_i,
   output logic [1+3+TGT_BITS+DATA_BITS+1+ID_BITS+PRIORITY_BITS-1:0] word_o
);
   import pce_pkg::*;

   typedef struct packed {
      logic                     live;
      logic [2:0]               op;
      logic [TGT_BITS-1:0]      tgt;
      logic [DATA_BITS-1:0]     data;
      logic                     hit;
      logic [ID_BITS-1:0]       bid;
      logic [PRIORITY_BITS-1:0] prio;
   } word_type;

   typedef struct packed {
      logic               en;
      logic [ID_BITS-1:0] id;
   } clr_type;

   word_type                 w, word_ff, word_in;
   clr_type                  clr;
   logic                     valid_ff, valid_in;
   logic [DATA_BITS-1:0]     data_ff, data_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in, prio_up;
   logic                     tgt_match;

   assign w         = word_i;
   assign clr       = clr_i;
   assign tgt_match = (w.tgt == TGT_BITS'(INDEX));
   assign prio_up   = (w.op == OP_PROMOTE && prio_ff != '1) ? prio_ff + 1'b1 : prio_ff;

   always_comb begin
      word_in  = w;
      valid_in = valid_ff;
      data_in  = data_ff;
      prio_in  = prio_ff;
      if (w.live) begin
         case (w.op)
            OP_ADD: begin
               if (tgt_match) begin
                  valid_in    = 1'b1;
                  data_in     = w.data;
                  prio_in     = '0;
                  word_in.hit = 1'b1;
                  word_in.bid = ID_BITS'(INDEX);
               end
            end
            OP_PROMOTE, OP_READ: begin
               if (tgt_match && valid_ff) begin
                  prio_in      = prio_up;
                  word_in.hit  = 1'b1;
                  word_in.bid  = ID_BITS'(INDEX);
                  word_in.data = data_ff;
                  word_in.prio = prio_up;
               end
            end
            OP_PEEK, OP_POP: begin
               if (valid_ff && (!w.hit || prio_ff >= w.prio)) begin
                  word_in.hit  = 1'b1;
                  word_in.bid  = ID_BITS'(INDEX);
                  word_in.data = data_ff;
                  word_in.prio = prio_ff;
               end
            end
            default: ;
         endcase
      end
      if (clr.en && clr.id == ID_BITS'(INDEX)) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         word_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         word_ff  <= word_in;
      end
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign word_o = word_ff;

endmodule
